>>> src/tlb_pkg.sv
// Shared types and constants for the fully associative TLB.
// Used by tlb_ctrl, tlb_dp and the top level tlb_fifo_lru; depends on nothing.
package tlb_pkg;

  // Default geometry of the table.
  localparam int unsigned TLB_ENTRIES_DEF = 16;
  localparam int unsigned PAGE_BITS_DEF   = 20;
  localparam int unsigned FRAME_BITS_DEF  = 20;
  localparam int unsigned PID_BITS_DEF    = 16;
  localparam int unsigned AGE_BITS_DEF    = 8;

  // Fixed field widths.
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned EIU_W      = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_MODE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED = 1'd1;

  // Reset value of the entries-in-use register.
  localparam logic [EIU_W-1:0] EIU_RESET = 5'd16;

  // Replacement modes.
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  // Item actions.
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_FILL   = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_SCAN,
    S_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic match_lookup;
    logic fill_direct;
    logic scan_init;
    logic scan_step;
    logic fill_best;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_fill;
    logic need_scan;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/tlb_ctrl.sv
// Controller state machine of the TLB: sequences match, victim scan and result transfer.
// Depends on tlb_pkg for the state enum and the command and status structs.
module tlb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tlb_pkg::dp_status_t status_i,
  output tlb_pkg::dp_cmd_t    cmd_o
);

  tlb_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tlb_pkg::S_IDLE: begin
        if (in_valid_i) state_d = tlb_pkg::S_MATCH;
      end
      tlb_pkg::S_MATCH: begin
        if (status_i.is_fill && status_i.need_scan) begin
          state_d = tlb_pkg::S_SCAN;
        end else begin
          state_d = tlb_pkg::S_EMIT;
        end
      end
      tlb_pkg::S_SCAN: begin
        if (status_i.scan_done) state_d = tlb_pkg::S_EMIT;
      end
      tlb_pkg::S_EMIT: begin
        if (status_i.out_free) state_d = tlb_pkg::S_IDLE;
      end
      default: state_d = tlb_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      tlb_pkg::S_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
      end
      tlb_pkg::S_MATCH: begin
        if (!status_i.is_fill) begin
          cmd_o.match_lookup = 1'b1;
        end else if (status_i.need_scan) begin
          cmd_o.scan_init = 1'b1;
        end else begin
          cmd_o.fill_direct = 1'b1;
        end
      end
      tlb_pkg::S_SCAN: begin
        if (status_i.scan_done) begin
          cmd_o.fill_best = 1'b1;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      tlb_pkg::S_EMIT: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> src/tlb_dp.sv
// Datapath of the TLB: configuration, tag compare, entry storage, ages, victim choice
// and the output register. Depends on tlb_pkg; driven by commands from tlb_ctrl.
module tlb_dp #(
  parameter int unsigned TLB_ENTRIES = tlb_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_BITS   = tlb_pkg::PAGE_BITS_DEF,
  parameter int unsigned FRAME_BITS  = tlb_pkg::FRAME_BITS_DEF,
  parameter int unsigned PID_BITS    = tlb_pkg::PID_BITS_DEF,
  parameter int unsigned AGE_BITS    = tlb_pkg::AGE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tlb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tlb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              action_i,
  input  logic [PID_BITS-1:0]               pid_i,
  input  logic [PAGE_BITS-1:0]              page_i,
  input  logic [FRAME_BITS-1:0]             new_frame_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              hit_o,
  output logic [FRAME_BITS-1:0]             frame_o,
  output logic [tlb_pkg::SLOT_W-1:0]        slot_o,
  input  tlb_pkg::dp_cmd_t                  cmd_i,
  output tlb_pkg::dp_status_t               status_o
);

  localparam int unsigned IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TLB_ENTRIES + 1);

  // Configuration registers.
  logic                      mode_q;
  logic [tlb_pkg::EIU_W-1:0] eiu_q;

  // Current item.
  logic                  item_action_q;
  logic [PID_BITS-1:0]   item_pid_q;
  logic [PAGE_BITS-1:0]  item_page_q;
  logic [FRAME_BITS-1:0] item_frame_q;

  // Table storage.
  logic [TLB_ENTRIES-1:0] valid_q;
  logic [PID_BITS-1:0]    pid_tab_q  [TLB_ENTRIES];
  logic [PAGE_BITS-1:0]   page_tab_q [TLB_ENTRIES];
  logic [AGE_BITS-1:0]    age_q      [TLB_ENTRIES];
  logic [FRAME_BITS-1:0]  frame_mem  [TLB_ENTRIES];
  logic [IDX_W-1:0]       fifo_ptr_q;

  // Per-item results.
  logic                  res_hit_q;
  logic [IDX_W-1:0]      res_slot_q;
  logic [FRAME_BITS-1:0] rd_frame_q;

  // Victim scan.
  logic [CNT_W-1:0]    scan_idx_q;
  logic [IDX_W-1:0]    best_q;
  logic [AGE_BITS-1:0] best_age_q;
  logic [AGE_BITS-1:0] scan_age;

  // Output register.
  logic                       out_valid_q;
  logic                       out_hit_q;
  logic [FRAME_BITS-1:0]      out_frame_q;
  logic [tlb_pkg::SLOT_W-1:0] out_slot_q;

  // Compare and selection signals.
  logic [CNT_W-1:0]       n_act;
  logic [TLB_ENTRIES-1:0] in_use;
  logic [TLB_ENTRIES-1:0] match_vec;
  logic [TLB_ENTRIES-1:0] free_vec;
  logic [IDX_W-1:0]       hit_idx;
  logic [IDX_W-1:0]       free_idx;
  logic                   hit_any;
  logic                   full;
  logic [IDX_W-1:0]       fifo_best;
  logic [CNT_W-1:0]       fifo_inc;
  logic [IDX_W-1:0]       fifo_next;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic                   out_free;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tlb_pkg::MODE_FIFO;
      eiu_q  <= tlb_pkg::EIU_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tlb_pkg::CFG_REPL_MODE:    mode_q <= cfg_data_i[0];
        tlb_pkg::CFG_ENTRIES_USED: eiu_q  <= cfg_data_i[tlb_pkg::EIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture on an input transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_action_q <= action_i;
      item_pid_q    <= pid_i;
      item_page_q   <= page_i;
      item_frame_q  <= new_frame_i;
    end
  end

  // Active entry count, tag compare and priority encoders.
  always_comb begin
    if (eiu_q == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(eiu_q) > 32'(TLB_ENTRIES)) begin
      n_act = CNT_W'(TLB_ENTRIES);
    end else begin
      n_act = CNT_W'(eiu_q);
    end
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      in_use[i]    = CNT_W'(i) < n_act;
      match_vec[i] = valid_q[i] && in_use[i] &&
                     (pid_tab_q[i] == item_pid_q) && (page_tab_q[i] == item_page_q);
      free_vec[i]  = in_use[i] && !valid_q[i];
    end
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_idx = IDX_W'(i);
      if (free_vec[i])  free_idx = IDX_W'(i);
    end
    hit_any = |match_vec;
    full    = ~|free_vec;
  end

  // FIFO pointer: a stale pointer beyond the active range acts as zero.
  always_comb begin
    fifo_best = (CNT_W'(fifo_ptr_q) < n_act) ? fifo_ptr_q : '0;
    fifo_inc  = CNT_W'(fifo_best) + CNT_W'(1);
    fifo_next = (fifo_inc < n_act) ? IDX_W'(fifo_inc) : '0;
  end

  // Entry write port, shared by direct fills and fills after a scan.
  always_comb begin
    wr_en  = cmd_i.fill_direct || cmd_i.fill_best;
    wr_idx = cmd_i.fill_best ? best_q : (full ? fifo_best : free_idx);
  end

  // Valid bits and FIFO pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      fifo_ptr_q <= '0;
    end else begin
      if (wr_en) valid_q[wr_idx] <= 1'b1;
      if (cmd_i.fill_direct && full) fifo_ptr_q <= fifo_next;
    end
  end

  // Tags, written on fill.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pid_tab_q[wr_idx]  <= item_pid_q;
      page_tab_q[wr_idx] <= item_page_q;
    end
  end

  // Frame memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) frame_mem[wr_idx] <= item_frame_q;
    if (cmd_i.match_lookup) rd_frame_q <= frame_mem[hit_idx];
  end

  // Ages: a hit in LRU mode ages every entry and clears the hit one; a fill clears its entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TLB_ENTRIES; i++) age_q[i] <= '0;
    end else if (cmd_i.match_lookup && hit_any && (mode_q == tlb_pkg::MODE_LRU)) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (IDX_W'(i) == hit_idx) begin
          age_q[i] <= '0;
        end else if (age_q[i] != '1) begin
          age_q[i] <= age_q[i] + AGE_BITS'(1);
        end
      end
    end else if (wr_en) begin
      age_q[wr_idx] <= '0;
    end
  end

  // Oldest-age scan, one entry per cycle; the lowest index wins a tie.
  assign scan_age = age_q[scan_idx_q[IDX_W-1:0]];

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      scan_idx_q <= CNT_W'(1);
      best_q     <= '0;
      best_age_q <= age_q[0];
    end else if (cmd_i.scan_step) begin
      scan_idx_q <= scan_idx_q + CNT_W'(1);
      if (scan_age > best_age_q) begin
        best_q     <= scan_idx_q[IDX_W-1:0];
        best_age_q <= scan_age;
      end
    end
  end

  // Result of the current item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.match_lookup) begin
      res_hit_q  <= hit_any;
      res_slot_q <= hit_any ? hit_idx : '0;
    end else if (wr_en) begin
      res_hit_q  <= 1'b0;
      res_slot_q <= wr_idx;
    end
  end

  // Output register; it frees when the current result transfers.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_hit_q  <= res_hit_q;
      out_slot_q <= tlb_pkg::SLOT_W'(res_slot_q);
      if (item_action_q == tlb_pkg::ACT_FILL) begin
        out_frame_q <= item_frame_q;
      end else begin
        out_frame_q <= res_hit_q ? rd_frame_q : '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign frame_o     = out_frame_q;
  assign slot_o      = out_slot_q;

  // Status toward the controller.
  always_comb begin
    status_o.is_fill   = item_action_q == tlb_pkg::ACT_FILL;
    status_o.need_scan = full && (mode_q == tlb_pkg::MODE_LRU);
    status_o.scan_done = scan_idx_q == n_act;
    status_o.out_free  = out_free;
  end

endmodule

>>> src/tlb_fifo_lru.sv
// Top level of the fully associative TLB with FIFO or LRU replacement.
// Depends on tlb_pkg, tlb_ctrl and tlb_dp.
//
//   channel  direction  handshake               payload
//   input    in         in_valid_i / in_stall_o action_i, pid_i, page_i, new_frame_i
//   result   out        out_valid_o/out_stall_i hit_o, frame_o, slot_o
//   config   in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// A lookup or a fill passes through capture, tag compare with frame read, and result load.
// A fill in LRU mode with all active entries valid adds an oldest-age scan of the active
// entries. Reset clears valid bits, ages, the FIFO pointer and the controller at once.
// A waiting result does not block the capture and compare of the next item; only its result
// load waits until the output register frees.
module tlb_fifo_lru #(
  parameter int unsigned TLB_ENTRIES = tlb_pkg::TLB_ENTRIES_DEF,
  parameter int unsigned PAGE_BITS   = tlb_pkg::PAGE_BITS_DEF,
  parameter int unsigned FRAME_BITS  = tlb_pkg::FRAME_BITS_DEF,
  parameter int unsigned PID_BITS    = tlb_pkg::PID_BITS_DEF,
  parameter int unsigned AGE_BITS    = tlb_pkg::AGE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tlb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [PID_BITS-1:0]            pid_i,
  input  logic [PAGE_BITS-1:0]           page_i,
  input  logic [FRAME_BITS-1:0]          new_frame_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           hit_o,
  output logic [FRAME_BITS-1:0]          frame_o,
  output logic [tlb_pkg::SLOT_W-1:0]     slot_o
);

  tlb_pkg::dp_cmd_t    cmd;
  tlb_pkg::dp_status_t status;

  // Controller.
  tlb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  tlb_dp #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_BITS   (PAGE_BITS),
    .FRAME_BITS  (FRAME_BITS),
    .PID_BITS    (PID_BITS),
    .AGE_BITS    (AGE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .action_i    (action_i),
    .pid_i       (pid_i),
    .page_i      (page_i),
    .new_frame_i (new_frame_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o),
    .frame_o     (frame_o),
    .slot_o      (slot_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
